// File: hdl/loc_pkg.sv
// package for the lock order checker: sizes, entry type, status codes and sequencer states
// used by every file of the block; depends on nothing

package loc_pkg;

  localparam int MAX_THREADS = 8;
  localparam int MAX_HELD    = 8;

  localparam int TID_W   = 8;
  localparam int LID_W   = 8;
  localparam int ORD_W   = 16;
  localparam int STATUS_W = 2;

  localparam int SLOT_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int HELD_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CNT_W  = $clog2(MAX_HELD + 1);
  localparam int DEPTH  = MAX_THREADS * MAX_HELD;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_VIOLATION = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_WALK
  } state_t;

  typedef struct packed {
    logic [LID_W-1:0] lock;
    logic [ORD_W-1:0] order;
  } entry_t;

  // flat address of one held entry of one thread slot
  function automatic logic [ADDR_W-1:0] entry_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [HELD_W-1:0] idx);
    int a;
    a = int'(slot) * MAX_HELD + int'(idx);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// File: hdl/loc_held_ram.sv
// held-lock list storage: one write port, one read port with registered read data
// depends on loc_pkg

module loc_held_ram (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [loc_pkg::ADDR_W-1:0] wr_addr,
  input  loc_pkg::entry_t          wr_data,
  input  logic [loc_pkg::ADDR_W-1:0] rd_addr,
  output loc_pkg::entry_t          rd_data
);

  loc_pkg::entry_t mem [loc_pkg::DEPTH];
  loc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/lock_order_violation_checker_core.sv
// Lock order checker. Per thread it keeps the list of held locks with their orders.
// Input: command style. A request (in_req_type, in_thread_id, in_lock_id, in_lock_order)
// is taken at a rising edge with start high and busy low. busy stays high while the
// request is worked on.
// Output: one result per request, out_status shown for exactly one cycle with out_valid
// high; the receiver cannot stall, so the result is never held back.
// Sequence: after the accepting edge, S_SEARCH walks the thread table one slot per cycle
// with a single tag compare, then S_DECIDE decides. An acquire to a known thread with
// room, or a release from a known thread, then walks every entry of the thread's list in
// S_WALK through the one read port of the held-list RAM (the list after the append on an
// acquire). The result cycle follows. busy falls in the cycle out_valid is high, so a new
// request can be taken in that cycle; a new request is not taken before the last result.
// Reset (rst_n low, synchronous) empties the thread table and all held counts; the RAM
// itself is not cleared since only entries below a slot's count are ever read.
// depends on loc_pkg and loc_held_ram

module lock_order_violation_checker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic [loc_pkg::TID_W-1:0]    in_thread_id,
  input  logic [loc_pkg::LID_W-1:0]    in_lock_id,
  input  logic [loc_pkg::ORD_W-1:0]    in_lock_order,
  output logic                         out_valid,
  output logic [loc_pkg::STATUS_W-1:0] out_status
);

  localparam logic [loc_pkg::SLOT_W-1:0] LAST_SLOT = loc_pkg::SLOT_W'(loc_pkg::MAX_THREADS - 1);
  localparam logic [loc_pkg::CNT_W-1:0]  FULL_CNT  = loc_pkg::CNT_W'(loc_pkg::MAX_HELD);

  loc_pkg::state_t state_r, state_nxt;

  logic                        req_r, req_nxt;
  logic [loc_pkg::TID_W-1:0]   tid_r, tid_nxt;
  logic [loc_pkg::LID_W-1:0]   lid_r, lid_nxt;
  logic [loc_pkg::ORD_W-1:0]   ord_r, ord_nxt;

  logic [loc_pkg::SLOT_W-1:0]  idx_r, idx_nxt;
  logic                        found_r, found_nxt;
  logic [loc_pkg::SLOT_W-1:0]  match_r, match_nxt;
  logic                        free_ok_r, free_ok_nxt;
  logic [loc_pkg::SLOT_W-1:0]  free_r, free_nxt;

  logic                        slot_valid_r [loc_pkg::MAX_THREADS];
  logic                        slot_valid_nxt [loc_pkg::MAX_THREADS];
  logic [loc_pkg::TID_W-1:0]   slot_thread_r [loc_pkg::MAX_THREADS];
  logic [loc_pkg::TID_W-1:0]   slot_thread_nxt [loc_pkg::MAX_THREADS];
  logic [loc_pkg::CNT_W-1:0]   held_count_r [loc_pkg::MAX_THREADS];
  logic [loc_pkg::CNT_W-1:0]   held_count_nxt [loc_pkg::MAX_THREADS];

  logic [loc_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [loc_pkg::CNT_W-1:0]   k_r, k_nxt;
  logic [loc_pkg::CNT_W-1:0]   w_r, w_nxt;
  logic                        rd_v_r, rd_v_nxt;
  logic                        rd_first_r, rd_first_nxt;
  logic [loc_pkg::ORD_W-1:0]   prev_r, prev_nxt;
  logic                        viol_r, viol_nxt;

  logic                        out_valid_r, out_valid_nxt;
  loc_pkg::status_t            out_status_r, out_status_nxt;

  logic                        ram_we;
  logic [loc_pkg::ADDR_W-1:0]  ram_waddr;
  loc_pkg::entry_t             ram_wdata;
  logic [loc_pkg::ADDR_W-1:0]  ram_raddr;
  loc_pkg::entry_t             ram_rdata;

  logic [loc_pkg::CNT_W-1:0]   cur_cnt;
  logic                        walk_done;

  assign cur_cnt   = held_count_r[match_r];
  assign walk_done = (k_r == n_r) && !rd_v_r;

  loc_held_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      loc_pkg::S_IDLE: begin
        if (start) state_nxt = loc_pkg::S_SEARCH;
      end
      loc_pkg::S_SEARCH: begin
        if (idx_r == LAST_SLOT) state_nxt = loc_pkg::S_DECIDE;
      end
      loc_pkg::S_DECIDE: begin
        if (found_r && (req_r == loc_pkg::REQ_RELEASE || cur_cnt < FULL_CNT)) begin
          state_nxt = loc_pkg::S_WALK;
        end else begin
          state_nxt = loc_pkg::S_IDLE;
        end
      end
      loc_pkg::S_WALK: begin
        if (walk_done) state_nxt = loc_pkg::S_IDLE;
      end
      default: state_nxt = loc_pkg::S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    req_nxt         = req_r;
    tid_nxt         = tid_r;
    lid_nxt         = lid_r;
    ord_nxt         = ord_r;
    idx_nxt         = idx_r;
    found_nxt       = found_r;
    match_nxt       = match_r;
    free_ok_nxt     = free_ok_r;
    free_nxt        = free_r;
    slot_valid_nxt  = slot_valid_r;
    slot_thread_nxt = slot_thread_r;
    held_count_nxt  = held_count_r;
    n_nxt           = n_r;
    k_nxt           = k_r;
    w_nxt           = w_r;
    rd_v_nxt        = 1'b0;
    rd_first_nxt    = rd_first_r;
    prev_nxt        = prev_r;
    viol_nxt        = viol_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = loc_pkg::entry_addr(match_r, w_r[loc_pkg::HELD_W-1:0]);
    ram_wdata       = ram_rdata;
    ram_raddr       = loc_pkg::entry_addr(match_r, k_r[loc_pkg::HELD_W-1:0]);

    unique case (state_r)
      loc_pkg::S_IDLE: begin
        if (start) begin
          req_nxt     = in_req_type;
          tid_nxt     = in_thread_id;
          lid_nxt     = in_lock_id;
          ord_nxt     = in_lock_order;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
        end
      end

      loc_pkg::S_SEARCH: begin
        if (slot_valid_r[idx_r] && slot_thread_r[idx_r] == tid_r) begin
          found_nxt = 1'b1;
          match_nxt = idx_r;
        end
        if (!slot_valid_r[idx_r] && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_nxt    = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
      end

      loc_pkg::S_DECIDE: begin
        k_nxt    = '0;
        w_nxt    = '0;
        viol_nxt = 1'b0;
        if (req_r == loc_pkg::REQ_ACQUIRE) begin
          ram_wdata.lock  = lid_r;
          ram_wdata.order = ord_r;
          if (!found_r) begin
            out_valid_nxt = 1'b1;
            if (!free_ok_r) begin
              out_status_nxt = loc_pkg::ST_FULL;
            end else begin
              // new thread: its lock is the only entry, so the order holds
              slot_valid_nxt[free_r]  = 1'b1;
              slot_thread_nxt[free_r] = tid_r;
              held_count_nxt[free_r]  = loc_pkg::CNT_W'(1);
              ram_we                  = 1'b1;
              ram_waddr               = loc_pkg::entry_addr(free_r, '0);
              out_status_nxt          = loc_pkg::ST_OK;
            end
          end else if (cur_cnt >= FULL_CNT) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = loc_pkg::ST_FULL;
          end else begin
            ram_we                  = 1'b1;
            ram_waddr               = loc_pkg::entry_addr(match_r,
                                                          cur_cnt[loc_pkg::HELD_W-1:0]);
            held_count_nxt[match_r] = cur_cnt + 1'b1;
            n_nxt                   = cur_cnt + 1'b1;
          end
        end else begin
          if (!found_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = loc_pkg::ST_UNKNOWN;
          end else begin
            n_nxt = cur_cnt;
          end
        end
      end

      loc_pkg::S_WALK: begin
        // one read issued per cycle, read data comes back through the RAM's output register
        if (k_r != n_r) begin
          rd_v_nxt     = 1'b1;
          rd_first_nxt = (k_r == '0);
          k_nxt        = k_r + 1'b1;
        end
        if (rd_v_r) begin
          if (req_r == loc_pkg::REQ_ACQUIRE) begin
            if (!rd_first_r && ram_rdata.order < prev_r) viol_nxt = 1'b1;
            prev_nxt = ram_rdata.order;
          end else if (ram_rdata.lock != lid_r) begin
            // compact the survivors toward the head of the list
            ram_we = 1'b1;
            w_nxt  = w_r + 1'b1;
          end
        end
        if (walk_done) begin
          out_valid_nxt = 1'b1;
          if (req_r == loc_pkg::REQ_ACQUIRE) begin
            out_status_nxt = viol_r ? loc_pkg::ST_VIOLATION : loc_pkg::ST_OK;
          end else begin
            held_count_nxt[match_r] = w_r;
            out_status_nxt          = loc_pkg::ST_OK;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= loc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      for (int i = 0; i < loc_pkg::MAX_THREADS; i++) begin
        slot_valid_r[i] <= 1'b0;
        held_count_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_v_r       <= rd_v_nxt;
      slot_valid_r <= slot_valid_nxt;
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    tid_r         <= tid_nxt;
    lid_r         <= lid_nxt;
    ord_r         <= ord_nxt;
    idx_r         <= idx_nxt;
    found_r       <= found_nxt;
    match_r       <= match_nxt;
    free_ok_r     <= free_ok_nxt;
    free_r        <= free_nxt;
    slot_thread_r <= slot_thread_nxt;
    n_r           <= n_nxt;
    k_r           <= k_nxt;
    w_r           <= w_nxt;
    rd_first_r    <= rd_first_nxt;
    prev_r        <= prev_nxt;
    viol_r        <= viol_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign busy       = (state_r != loc_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

// File: hdl/loc_checker.sv
// port-level checks for the lock order checker, bound to the top level
// depends on loc_pkg and lock_order_violation_checker_core

module loc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [loc_pkg::STATUS_W-1:0] out_status
);

  // an accepted transfer makes the block busy once the request is registered
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  // the result strobe is never high on consecutive clock edges
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a result only appears once the work is finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // every finished request gives a result as busy drops
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // back-to-back results need a request in between: busy high in the cycle between them
  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid, 2) |-> $past(busy))
    else $error("results too close together, status %0d", out_status);

endmodule

bind lock_order_violation_checker_core loc_checker u_loc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_status (out_status)
);

// File: test/tb_lock_order_violation_checker_core.sv
// testbench for lock_order_violation_checker_core: directed lock/unlock sequences, then
// random per-thread traffic in bursts; every status is checked against an in-bench model
// depends on loc_pkg and the checker core

module tb_lock_order_violation_checker_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 20;

  typedef struct {
    loc_pkg::status_t          status;
    logic                      req;
    logic [loc_pkg::TID_W-1:0] tid;
    logic [loc_pkg::LID_W-1:0] lid;
  } lock_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_req_type = loc_pkg::REQ_ACQUIRE;
  logic [loc_pkg::TID_W-1:0]    in_thread_id = '0;
  logic [loc_pkg::LID_W-1:0]    in_lock_id = '0;
  logic [loc_pkg::ORD_W-1:0]    in_lock_order = '0;
  logic                         out_valid;
  logic [loc_pkg::STATUS_W-1:0] out_status;

  // model of the thread table and the per-thread held lists
  logic                      thr_valid [loc_pkg::MAX_THREADS] = '{default: 1'b0};
  logic [loc_pkg::TID_W-1:0] thr_tag [loc_pkg::MAX_THREADS];
  int                        held_n [loc_pkg::MAX_THREADS] = '{default: 0};
  logic [loc_pkg::LID_W-1:0] held_lid [loc_pkg::MAX_THREADS][loc_pkg::MAX_HELD];
  logic [loc_pkg::ORD_W-1:0] held_ord [loc_pkg::MAX_THREADS][loc_pkg::MAX_HELD];

  lock_result_t status_q [$];
  int           err_count = 0;
  int           cycle_cnt = 0;

  lock_order_violation_checker_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_thread_id (in_thread_id),
    .in_lock_id   (in_lock_id),
    .in_lock_order(in_lock_order),
    .out_valid    (out_valid),
    .out_status   (out_status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int thread_slot(input logic [loc_pkg::TID_W-1:0] tid);
    int s, k;
    s = -1;
    for (k = loc_pkg::MAX_THREADS - 1; k >= 0; k--)
      if (thr_valid[k] && thr_tag[k] == tid) s = k;
    return s;
  endfunction

  function automatic loc_pkg::status_t predict_status(input logic req,
                                                      input logic [loc_pkg::TID_W-1:0] tid,
                                                      input logic [loc_pkg::LID_W-1:0] lid,
                                                      input logic [loc_pkg::ORD_W-1:0] ord);
    int s, k, w;
    s = thread_slot(tid);
    if (req == loc_pkg::REQ_RELEASE) begin
      if (s < 0) return loc_pkg::ST_UNKNOWN;
      w = 0;
      // drop every entry of this lock, keep the rest in order
      for (k = 0; k < held_n[s]; k++)
        if (held_lid[s][k] != lid) begin
          held_lid[s][w] = held_lid[s][k];
          held_ord[s][w] = held_ord[s][k];
          w++;
        end
      held_n[s] = w;
      return loc_pkg::ST_OK;
    end
    if (s < 0) begin
      for (k = loc_pkg::MAX_THREADS - 1; k >= 0; k--)
        if (!thr_valid[k]) s = k;
      if (s < 0) return loc_pkg::ST_FULL;
      thr_valid[s] = 1'b1;
      thr_tag[s] = tid;
      held_n[s] = 0;
    end
    if (held_n[s] >= loc_pkg::MAX_HELD) return loc_pkg::ST_FULL;
    held_lid[s][held_n[s]] = lid;
    held_ord[s][held_n[s]] = ord;
    held_n[s]++;
    for (k = 1; k < held_n[s]; k++)
      if (held_ord[s][k] < held_ord[s][k-1]) return loc_pkg::ST_VIOLATION;
    return loc_pkg::ST_OK;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
  endtask

  task automatic send_request(input logic req, input logic [loc_pkg::TID_W-1:0] tid,
                              input logic [loc_pkg::LID_W-1:0] lid,
                              input logic [loc_pkg::ORD_W-1:0] ord);
    lock_result_t exp;
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= req;
    in_thread_id <= tid;
    in_lock_id <= lid;
    in_lock_order <= ord;
    do @(posedge clk); while (busy !== 1'b0);
    exp.status = predict_status(req, tid, lid, ord);
    exp.req = req;
    exp.tid = tid;
    exp.lid = lid;
    status_q.insert(status_q.size(), exp);
  endtask

  // sender idle: start low, fields carry noise
  task automatic idle_gap(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      @(negedge clk);
      start <= 1'b0;
      in_req_type <= 1'($urandom);
      in_thread_id <= loc_pkg::TID_W'($urandom);
      in_lock_id <= loc_pkg::LID_W'($urandom);
      in_lock_order <= loc_pkg::ORD_W'($urandom);
    end
  endtask

  always @(posedge clk) begin : check_results
    lock_result_t exp;
    if (rst_n && out_valid !== 1'b0) begin
      if (status_q.size() == 0) begin
        report_mismatch($sformatf("status %0d with no request pending", out_status));
      end else begin
        exp = status_q.pop_front();
        if (out_valid !== 1'b1 || out_status !== exp.status)
          report_mismatch($sformatf("req %0d tid %0h lid %0h: status %0d valid %b, want %0d",
                                    exp.req, exp.tid, exp.lid, out_status, out_valid,
                                    exp.status));
      end
    end
  end

  task automatic test_first_acquire_and_nesting();
    send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'h00, 16'h0000);
    send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'hFF, 16'hFFFF);
    send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'h05, 16'hFFFF);
  endtask

  task automatic test_order_violation();
    send_request(loc_pkg::REQ_ACQUIRE, 8'hFF, 8'h01, 16'd100);
    send_request(loc_pkg::REQ_ACQUIRE, 8'hFF, 8'h02, 16'd50);
    send_request(loc_pkg::REQ_ACQUIRE, 8'hFF, 8'h03, 16'd200);
    // order field must not matter on release
    send_request(loc_pkg::REQ_RELEASE, 8'hFF, 8'h02, 16'hFFFF);
    send_request(loc_pkg::REQ_ACQUIRE, 8'hFF, 8'h04, 16'd300);
  endtask

  task automatic test_release_cases();
    send_request(loc_pkg::REQ_RELEASE, 8'h5A, 8'h01, 16'h0000);
    send_request(loc_pkg::REQ_RELEASE, 8'h00, 8'h4D, 16'h1234);
    send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'h00, 16'hFFFF);
    // lock 0 is held twice now, both entries go
    send_request(loc_pkg::REQ_RELEASE, 8'h00, 8'h00, 16'h0000);
    send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'h09, 16'h0000);
  endtask

  task automatic test_held_list_full();
    int s;
    s = thread_slot(8'h00);
    while (held_n[s] < loc_pkg::MAX_HELD)
      send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'h80 + loc_pkg::LID_W'(held_n[s]), 16'hFFFF);
    send_request(loc_pkg::REQ_ACQUIRE, 8'h00, 8'h33, 16'hFFFF);
  endtask

  task automatic test_thread_table_full();
    int k;
    for (k = 0; k < loc_pkg::MAX_THREADS; k++)
      if (!thr_valid[k]) send_request(loc_pkg::REQ_ACQUIRE, 8'h10 + loc_pkg::TID_W'(k),
                                      loc_pkg::LID_W'(k), loc_pkg::ORD_W'(k * 1000));
    send_request(loc_pkg::REQ_ACQUIRE, 8'hC3, 8'h01, 16'h0001);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                        i, burst, s, cnt, nxt;
    logic                      req;
    logic [loc_pkg::TID_W-1:0] tid;
    logic [loc_pkg::LID_W-1:0] lid;
    logic [loc_pkg::ORD_W-1:0] ord;
    burst = 0;
    for (i = 0; i < n_items; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 9) < 7) idle_gap($urandom_range(1, 25));
      end
      burst--;
      // mostly known threads, a few strangers
      if ($urandom_range(0, 9) == 0) tid = loc_pkg::TID_W'($urandom);
      else tid = thr_tag[$urandom_range(0, loc_pkg::MAX_THREADS - 1)];
      s = thread_slot(tid);
      cnt = (s < 0) ? 0 : held_n[s];
      if (cnt == 0) begin
        req = ($urandom_range(0, 9) < 8) ? loc_pkg::REQ_ACQUIRE : loc_pkg::REQ_RELEASE;
      end else if (cnt >= loc_pkg::MAX_HELD) begin
        req = ($urandom_range(0, 9) < 8) ? loc_pkg::REQ_RELEASE : loc_pkg::REQ_ACQUIRE;
      end else begin
        req = ($urandom_range(0, 99) < 55) ? loc_pkg::REQ_ACQUIRE : loc_pkg::REQ_RELEASE;
      end
      if (req == loc_pkg::REQ_ACQUIRE) begin
        if ($urandom_range(0, 3) == 0) lid = loc_pkg::LID_W'($urandom);
        else lid = loc_pkg::LID_W'($urandom_range(0, 15));
        if (cnt == 0 || $urandom_range(0, 4) == 0) begin
          ord = loc_pkg::ORD_W'($urandom);
        end else begin
          nxt = int'(held_ord[s][cnt-1]) + $urandom_range(0, 300);
          if (nxt > 65535) nxt = 65535;
          ord = loc_pkg::ORD_W'(nxt);
        end
      end else begin
        if (cnt > 0 && $urandom_range(0, 9) < 7) lid = held_lid[s][$urandom_range(0, cnt - 1)];
        else lid = loc_pkg::LID_W'($urandom);
        ord = loc_pkg::ORD_W'($urandom);
      end
      send_request(req, tid, lid, ord);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_first_acquire_and_nesting();
    test_order_violation();
    test_release_cases();
    test_held_list_full();
    test_thread_table_full();
    test_random_traffic(1925);
    idle_gap(1);
    while (status_q.size() != 0) @(posedge clk);
    // catch any stray transfer after the last expected one
    repeat (40) @(posedge clk);
    if (err_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// File: lock_order_violation_checker_core.f
hdl/loc_pkg.sv
hdl/loc_held_ram.sv
hdl/lock_order_violation_checker_core.sv
hdl/loc_checker.sv
test/tb_lock_order_violation_checker_core.sv
